[sv/gdr_pkg.sv]
// Shared types, constants and helpers of the grid raycaster.
package gdr_pkg;

    localparam int MAP_SIZE      = 32;
    localparam int MAP_W         = 5;
    localparam int ADDR_W        = 2 * MAP_W;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int FRAC_BITS     = 16;

    localparam int KIND_W  = 3;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int COLOR_W = 24;
    localparam int DIST_W  = 22;
    localparam int POS_W   = 21;
    localparam int VEC_W   = 19;
    localparam int RAY_W   = 24;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DELTA_W = 2 * FRAC_BITS + 1;
    localparam int SIDE_W  = 40;
    localparam int CELL_W  = MAP_W + 2;
    localparam int LH_W    = 10;
    localparam int STEP_W  = 7;
    localparam int CFG_W   = POS_W;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;

    // camera offset 2*col*2^F/W as a reciprocal multiply, exact for 10-bit columns
    localparam int CAM_SHIFT   = 13;
    localparam int CAM_RECIP_W = 21;
    localparam int CAM_PROD_W  = COL_W + CAM_RECIP_W;
    localparam logic [CAM_RECIP_W-1:0] CAM_RECIP = CAM_RECIP_W'(
        ((64'd1 << (CAM_SHIFT + FRAC_BITS + 1)) + SCREEN_WIDTH - 1) / SCREEN_WIDTH);

    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(2 * MAP_SIZE + 2);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [LH_W-1:0]   LINE_MAX = LH_W'(2 * SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0]  HALF_H   = ROW_W'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [DELTA_W-1:0] DELTA_MAX = {1'b1, {(DELTA_W-1){1'b0}}};
    localparam logic [DIV_NUM_W-1:0] DELTA_NUM = DIV_NUM_W'(DELTA_MAX);
    localparam logic [DIV_NUM_W-1:0] LINE_NUM  = DIV_NUM_W'(SCREEN_HEIGHT) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_A = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [POS_W-1:0] PLAYER_X_RST = POS_W'(786432);
    localparam logic [POS_W-1:0] PLAYER_Y_RST = POS_W'(327680);
    localparam logic [VEC_W-1:0] DIR_X_RST    = VEC_W'(-65536);
    localparam logic [VEC_W-1:0] DIR_Y_RST    = VEC_W'(0);
    localparam logic [VEC_W-1:0] PLANE_X_RST  = VEC_W'(0);
    localparam logic [VEC_W-1:0] PLANE_Y_RST  = VEC_W'(43254);

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAM,
        ST_RAYX,
        ST_RAYY,
        ST_DLX,
        ST_DLY,
        ST_SXHI,
        ST_SXLO,
        ST_SYHI,
        ST_SYLO,
        ST_SYADD,
        ST_WALK,
        ST_LOOK,
        ST_DIST,
        ST_LINE,
        ST_FINISH
    } gdr_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic [ROW_W-1:0]   wall_top;
        logic [ROW_W-1:0]   wall_bottom;
        logic [COLOR_W-1:0] wall_color;
        logic               hit_side;
        logic [DIST_W-1:0]  wall_distance;
        logic [KIND_W-1:0]  hit_kind;
        logic [MAP_W-1:0]   hit_x;
        logic [MAP_W-1:0]   hit_y;
        logic               left_map;
    } gdr_result_t;

    function automatic logic [COLOR_W-1:0] kind_color(input logic [KIND_W-1:0] kind);
        logic [COLOR_W-1:0] c;
        case (kind)
            3'd1:    c = 24'hFF0000;
            3'd2:    c = 24'h00FF00;
            3'd3:    c = 24'h0000FF;
            3'd4:    c = 24'hFFFFFF;
            default: c = 24'hFFFF00;
        endcase
        return c;
    endfunction

    function automatic logic [RAY_W-1:0] abs_ray(input logic signed [RAY_W-1:0] v);
        return v[RAY_W-1] ? (~v + RAY_W'(1)) : v;
    endfunction

endpackage

[sv/gdr_in_if.sv]
// Input channel: cell write and column cast words.
interface gdr_in_if
    import gdr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [COL_W-1:0]  column;
    logic [MAP_W-1:0]  cell_x;
    logic [MAP_W-1:0]  cell_y;
    logic [KIND_W-1:0] cell_kind;

    modport source (output valid, command, column, cell_x, cell_y, cell_kind, input ready);
    modport sink   (input valid, command, column, cell_x, cell_y, cell_kind, output ready);
endinterface

[sv/gdr_out_if.sv]
// Output channel: one result word per cast column.
interface gdr_out_if
    import gdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   wall_top;
    logic [ROW_W-1:0]   wall_bottom;
    logic [COLOR_W-1:0] wall_color;
    logic               hit_side;
    logic [DIST_W-1:0]  wall_distance;
    logic [KIND_W-1:0]  hit_kind;
    logic [MAP_W-1:0]   hit_x;
    logic [MAP_W-1:0]   hit_y;
    logic               left_map;

    modport source (output valid, out_column, wall_top, wall_bottom, wall_color, hit_side,
                    wall_distance, hit_kind, hit_x, hit_y, left_map, input ready);
    modport sink   (input valid, out_column, wall_top, wall_bottom, wall_color, hit_side,
                    wall_distance, hit_kind, hit_x, hit_y, left_map, output ready);
endinterface

[sv/gdr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module gdr_div
    import gdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0] shifted;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

[sv/gdr_map.sv]
// Map cell store with a clearing sweep after reset.
module gdr_map
    import gdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KIND_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KIND_W-1:0] rd_data,
    output logic              clearing
);

    logic [KIND_W-1:0] mem [MAP_SIZE*MAP_SIZE];
    logic [ADDR_W:0]   clr_cnt_reg;
    logic [KIND_W-1:0] rd_data_reg;

    assign clearing = !clr_cnt_reg[ADDR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_cnt_reg[ADDR_W-1:0]] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/grid_dda_raycast_column.sv]
// Top level: column raycaster sequencer over a shared divider and multiplier.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+---------------------------------------
//  in_ch   | in  | valid/ready     | command, column, cell_x/y, cell_kind
//  out_ch  | out | valid/ready     | one result per cast column
//  cfg     | in  | cfg_we only     | cfg_index, cfg_data
//
// A cell write is taken in ST_IDLE. A cast computes the camera offset, runs four
// divisions on the shared divider, the multiplies and adds for the ray and side
// distances, a walk and a look state per grid step (map read port), and then
// loads the result; a zero distance skips its divisions.
// After reset the map is swept to empty with in_ch not ready.
// One finished result waits in the output register while the next word enters;
// a cast that finishes while that register is still full holds until it drains.
module grid_dda_raycast_column
    import gdr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    gdr_in_if.sink               in_ch,
    gdr_out_if.source            out_ch
);

    gdr_state_t state_reg, state_next;

    logic [POS_W-1:0] player_x_reg, player_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    logic [COL_W-1:0]         col_reg;
    logic signed [VEC_W-1:0]  cam_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [DELTA_W-1:0]       dlx_reg, dly_reg;
    logic [SIDE_W-1:0]        sx_reg, sy_reg;
    logic signed [CELL_W-1:0] mx_reg, my_reg;
    logic                     side_reg;
    logic [STEP_W-1:0]        cnt_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [LH_W-1:0]          lh_reg;
    logic                     left_reg;
    gdr_result_t              res_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     div_started_reg, div_started_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     div_done;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [CAM_PROD_W-1:0]   cam_prod;

    logic in_fire, load_res;
    logic map_we;
    logic [ADDR_W-1:0] map_wr_addr, map_rd_addr;
    logic [KIND_W-1:0] map_rd_data;
    logic map_clearing;

    logic [RAY_W-1:0]  abs_rx, abs_ry, abs_r, abs_num;
    logic [FRAC_BITS:0] ax, ay;
    logic x_step, out_of_map;
    logic signed [CELL_W-1:0] mx_nxt, my_nxt, stepx, stepy;
    logic signed [RAY_W-1:0]  num_s, r_s;
    logic dist_zero_r, dist_opp;
    logic [ROW_W-1:0] half, top_c, bot_c;
    logic [ROW_W:0]   bot_sum;
    gdr_result_t result_c;

    localparam logic signed [CELL_W-1:0] MAP_LAST = CELL_W'(MAP_SIZE - 1);

    // ---- shared units ----
    gdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gdr_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (map_we),
        .wr_addr  (map_wr_addr),
        .wr_data  (in_ch.cell_kind),
        .rd_addr  (map_rd_addr),
        .rd_data  (map_rd_data),
        .clearing (map_clearing)
    );

    // ---- datapath helpers ----
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign load_res = (state_reg == ST_FINISH) && (!out_valid_reg || out_ch.ready);
    assign div_done = div_started_reg && div_rsp.done;

    assign map_we      = in_fire && (in_ch.command == CMD_WRITE);
    assign map_wr_addr = {in_ch.cell_y, in_ch.cell_x};

    assign cam_prod = CAM_PROD_W'(col_reg) * CAM_PROD_W'(CAM_RECIP);

    assign abs_rx = abs_ray(rx_reg);
    assign abs_ry = abs_ray(ry_reg);
    assign ax = rx_reg[RAY_W-1] ? {1'b0, player_x_reg[FRAC_BITS-1:0]}
                                : ONE_A - {1'b0, player_x_reg[FRAC_BITS-1:0]};
    assign ay = ry_reg[RAY_W-1] ? {1'b0, player_y_reg[FRAC_BITS-1:0]}
                                : ONE_A - {1'b0, player_y_reg[FRAC_BITS-1:0]};

    assign stepx  = rx_reg[RAY_W-1] ? -CELL_W'(1) : CELL_W'(1);
    assign stepy  = ry_reg[RAY_W-1] ? -CELL_W'(1) : CELL_W'(1);
    assign x_step = sx_reg < sy_reg;
    assign mx_nxt = x_step ? mx_reg + stepx : mx_reg;
    assign my_nxt = x_step ? my_reg : my_reg + stepy;
    assign out_of_map = (mx_nxt < 0) || (my_nxt < 0) || (mx_nxt > MAP_LAST)
                     || (my_nxt > MAP_LAST);
    assign map_rd_addr = {my_nxt[MAP_W-1:0], mx_nxt[MAP_W-1:0]};

    // boundary of the hit cell minus the player position on the crossed axis
    always_comb
    begin
        if (side_reg)
        begin
            num_s = (RAY_W'(my_reg) <<< FRAC_BITS) - RAY_W'(player_y_reg)
                  + (ry_reg[RAY_W-1] ? RAY_W'(ONE_A) : RAY_W'(0));
            r_s   = ry_reg;
            abs_r = abs_ry;
        end
        else
        begin
            num_s = (RAY_W'(mx_reg) <<< FRAC_BITS) - RAY_W'(player_x_reg)
                  + (rx_reg[RAY_W-1] ? RAY_W'(ONE_A) : RAY_W'(0));
            r_s   = rx_reg;
            abs_r = abs_rx;
        end
    end

    assign abs_num     = abs_ray(num_s);
    assign dist_zero_r = (r_s == '0);
    assign dist_opp    = (num_s != '0) && ((num_s < 0) != (r_s < 0));

    assign half    = lh_reg[LH_W-1:1];
    assign top_c   = (half > HALF_H) ? '0 : HALF_H - half;
    assign bot_sum = {1'b0, half} + {1'b0, HALF_H};
    assign bot_c   = (bot_sum > {1'b0, LAST_ROW}) ? LAST_ROW : bot_sum[ROW_W-1:0];

    always_comb
    begin
        result_c            = '0;
        result_c.out_column = col_reg;
        if (left_reg)
        begin
            result_c.left_map = 1'b1;
        end
        else
        begin
            result_c.wall_top      = top_c;
            result_c.wall_bottom   = bot_c;
            result_c.wall_color    = kind_color(kind_reg) >> side_reg;
            result_c.hit_side      = side_reg;
            result_c.wall_distance = dist_reg;
            result_c.hit_kind      = kind_reg;
            result_c.hit_x         = mx_reg[MAP_W-1:0];
            result_c.hit_y         = my_reg[MAP_W-1:0];
        end
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire && in_ch.command == CMD_CAST) state_next = ST_CAM;
            ST_CAM:    state_next = ST_RAYX;
            ST_RAYX:   state_next = ST_RAYY;
            ST_RAYY:   state_next = ST_DLX;
            ST_DLX:    if (div_done) state_next = ST_DLY;
            ST_DLY:    if (div_done) state_next = ST_SXHI;
            ST_SXHI:   state_next = ST_SXLO;
            ST_SXLO:   state_next = ST_SYHI;
            ST_SYHI:   state_next = ST_SYLO;
            ST_SYLO:   state_next = ST_SYADD;
            ST_SYADD:  state_next = ST_WALK;
            ST_WALK:   state_next = out_of_map ? ST_FINISH : ST_LOOK;
            ST_LOOK:
            begin
                if (map_rd_data != '0)
                    state_next = ST_DIST;
                else if (cnt_reg == STEP_MAX)
                    state_next = ST_FINISH;
                else
                    state_next = ST_WALK;
            end
            ST_DIST:
            begin
                if (!div_started_reg && (dist_zero_r || dist_opp))
                    state_next = ST_LINE;
                else if (div_done)
                    state_next = ST_LINE;
            end
            ST_LINE:
            begin
                if (!div_started_reg && dist_reg == '0)
                    state_next = ST_FINISH;
                else if (div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH: if (load_res) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---- unit control and handshake ----
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE) && !map_clearing;
        div_req     = '0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            ST_RAYX:
            begin
                mul_a = MUL_W'(plane_x_reg);
                mul_b = MUL_W'(cam_reg);
            end
            ST_RAYY:
            begin
                mul_a = MUL_W'(plane_y_reg);
                mul_b = MUL_W'(cam_reg);
            end
            ST_DLX:
            begin
                div_req.start = !div_started_reg;
                div_req.num   = DELTA_NUM;
                div_req.den   = abs_rx;
            end
            ST_DLY:
            begin
                div_req.start = !div_started_reg;
                div_req.num   = DELTA_NUM;
                div_req.den   = abs_ry;
            end
            ST_SXHI:
            begin
                mul_a = MUL_W'(ax);
                mul_b = MUL_W'(dlx_reg[DELTA_W-1:FRAC_BITS]);
            end
            ST_SXLO:
            begin
                mul_a = MUL_W'(ax);
                mul_b = MUL_W'(dlx_reg[FRAC_BITS-1:0]);
            end
            ST_SYHI:
            begin
                mul_a = MUL_W'(ay);
                mul_b = MUL_W'(dly_reg[DELTA_W-1:FRAC_BITS]);
            end
            ST_SYLO:
            begin
                mul_a = MUL_W'(ay);
                mul_b = MUL_W'(dly_reg[FRAC_BITS-1:0]);
            end
            ST_DIST:
            begin
                div_req.start = !div_started_reg && !dist_zero_r && !dist_opp;
                div_req.num   = DIV_NUM_W'({abs_num, {FRAC_BITS{1'b0}}});
                div_req.den   = abs_r;
            end
            ST_LINE:
            begin
                div_req.start = !div_started_reg && (dist_reg != '0);
                div_req.num   = LINE_NUM;
                div_req.den   = DIV_DEN_W'(dist_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_started_next = div_started_reg;
        if (div_req.start)
            div_started_next = 1'b1;
        else if (div_rsp.done)
            div_started_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_res)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            div_started_reg <= 1'b0;
            player_x_reg    <= PLAYER_X_RST;
            player_y_reg    <= PLAYER_Y_RST;
            dir_x_reg       <= DIR_X_RST;
            dir_y_reg       <= DIR_Y_RST;
            plane_x_reg     <= PLANE_X_RST;
            plane_y_reg     <= PLANE_Y_RST;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            div_started_reg <= div_started_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PLAYER_X: player_x_reg <= cfg_data;
                    REG_PLAYER_Y: player_y_reg <= cfg_data;
                    REG_DIR_X:    dir_x_reg    <= cfg_data[VEC_W-1:0];
                    REG_DIR_Y:    dir_y_reg    <= cfg_data[VEC_W-1:0];
                    REG_PLANE_X:  plane_x_reg  <= cfg_data[VEC_W-1:0];
                    REG_PLANE_Y:  plane_y_reg  <= cfg_data[VEC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (load_res)
            res_reg <= result_c;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_ch.command == CMD_CAST)
                begin
                    col_reg  <= in_ch.column;
                    left_reg <= 1'b0;
                end
            end
            ST_CAM:
                cam_reg <= VEC_W'(cam_prod[CAM_PROD_W-1:CAM_SHIFT]) - VEC_W'(ONE_A);
            ST_RAYY:
                rx_reg <= RAY_W'(dir_x_reg) + RAY_W'(prod_reg >>> FRAC_BITS);
            ST_DLX:
            begin
                if (!div_started_reg)
                    ry_reg <= RAY_W'(dir_y_reg) + RAY_W'(prod_reg >>> FRAC_BITS);
                if (div_done)
                    dlx_reg <= (abs_rx == '0) ? DELTA_MAX : div_rsp.quot[DELTA_W-1:0];
            end
            ST_DLY:
                if (div_done)
                    dly_reg <= (abs_ry == '0) ? DELTA_MAX : div_rsp.quot[DELTA_W-1:0];
            ST_SXLO:
                sx_reg <= SIDE_W'(prod_reg);
            ST_SYHI:
                sx_reg <= sx_reg + SIDE_W'($unsigned(prod_reg) >> FRAC_BITS);
            ST_SYLO:
                sy_reg <= SIDE_W'(prod_reg);
            ST_SYADD:
            begin
                sy_reg <= sy_reg + SIDE_W'($unsigned(prod_reg) >> FRAC_BITS);
                mx_reg <= CELL_W'(player_x_reg[POS_W-1:FRAC_BITS]);
                my_reg <= CELL_W'(player_y_reg[POS_W-1:FRAC_BITS]);
                cnt_reg <= '0;
            end
            ST_WALK:
            begin
                // advance along the axis whose next boundary is nearer
                if (x_step)
                    sx_reg <= sx_reg + SIDE_W'(dlx_reg);
                else
                    sy_reg <= sy_reg + SIDE_W'(dly_reg);
                mx_reg   <= mx_nxt;
                my_reg   <= my_nxt;
                side_reg <= !x_step;
                cnt_reg  <= cnt_reg + STEP_W'(1);
                if (out_of_map)
                    left_reg <= 1'b1;
            end
            ST_LOOK:
            begin
                kind_reg <= map_rd_data;
                if (map_rd_data == '0 && cnt_reg == STEP_MAX)
                    left_reg <= 1'b1;
            end
            ST_DIST:
            begin
                if (!div_started_reg && dist_zero_r)
                    dist_reg <= DIST_MAX;
                else if (!div_started_reg && dist_opp)
                    dist_reg <= '0;
                else if (div_done)
                    dist_reg <= (div_rsp.quot > DIV_NUM_W'(DIST_MAX))
                              ? DIST_MAX : div_rsp.quot[DIST_W-1:0];
            end
            ST_LINE:
            begin
                if (!div_started_reg && dist_reg == '0)
                    lh_reg <= LINE_MAX;
                else if (div_done)
                    lh_reg <= (div_rsp.quot > DIV_NUM_W'(LINE_MAX))
                            ? LINE_MAX : div_rsp.quot[LH_W-1:0];
            end
            default: ;
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_column    = res_reg.out_column;
    assign out_ch.wall_top      = res_reg.wall_top;
    assign out_ch.wall_bottom   = res_reg.wall_bottom;
    assign out_ch.wall_color    = res_reg.wall_color;
    assign out_ch.hit_side      = res_reg.hit_side;
    assign out_ch.wall_distance = res_reg.wall_distance;
    assign out_ch.hit_kind      = res_reg.hit_kind;
    assign out_ch.hit_x         = res_reg.hit_x;
    assign out_ch.hit_y         = res_reg.hit_y;
    assign out_ch.left_map      = res_reg.left_map;

endmodule

[tb/grid_dda_raycast_column_tb.sv]
// Testbench of the grid raycaster: directed and random map writes and column casts.
`timescale 1ns / 100ps

module grid_dda_raycast_column_tb;
    import gdr_pkg::*;

    localparam int  IDLE_LIMIT  = 6000;
    localparam int  DRAIN_WAIT  = 400;
    localparam longint ONE_Q    = 64'sd1 << FRAC_BITS;
    localparam longint DELTA_SAT = 64'sd1 << (2 * FRAC_BITS);
    localparam longint DIST_SAT = 64'sd4194303;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gdr_in_if  in_ch ();
    gdr_out_if out_ch ();

    grid_dda_raycast_column u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Shadow copy of the block state
    logic [KIND_W-1:0] shadow_map [MAP_SIZE*MAP_SIZE];
    logic [POS_W-1:0]  cur_px;
    logic [POS_W-1:0]  cur_py;
    logic [VEC_W-1:0]  cur_dir_x;
    logic [VEC_W-1:0]  cur_dir_y;
    logic [VEC_W-1:0]  cur_plane_x;
    logic [VEC_W-1:0]  cur_plane_y;

    gdr_result_t column_results_q [$];
    int          error_count;
    int          idle_cycles;
    int          out_stall;
    bit          out_taken;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint sext_vec(logic [VEC_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint step_len(longint r);
        return (r == 0) ? DELTA_SAT : DELTA_SAT / abs_l(r);
    endfunction

    function automatic longint frac_mul(longint a, longint b);
        return a * (b >>> FRAC_BITS) + ((a * (b & (ONE_Q - 1))) >>> FRAC_BITS);
    endfunction

    function automatic longint wall_dist(longint num, longint r);
        longint d;
        if (r == 0)
            return DIST_SAT;
        if (num != 0 && ((num < 0) != (r < 0)))
            return 0;
        d = (abs_l(num) << FRAC_BITS) / abs_l(r);
        return (d > DIST_SAT) ? DIST_SAT : d;
    endfunction

    function automatic gdr_result_t trace_column(logic [COL_W-1:0] col);
        gdr_result_t res;
        longint cam, rx, ry, mx, my, fx, fy, dlx, dly, sx, sy, stx, sty;
        longint num, wall_d, lh, top, bot;
        logic [KIND_W-1:0]  kind;
        logic [COLOR_W-1:0] color;
        bit hit;
        bit side;
        res = '0;
        res.out_column = col;
        kind = '0;
        hit = 1'b0;
        side = 1'b0;
        cam = ((longint'(col) * 2) << FRAC_BITS) / SCREEN_WIDTH - ONE_Q;
        rx = sext_vec(cur_dir_x) + ((sext_vec(cur_plane_x) * cam) >>> FRAC_BITS);
        ry = sext_vec(cur_dir_y) + ((sext_vec(cur_plane_y) * cam) >>> FRAC_BITS);
        mx = longint'(cur_px) >>> FRAC_BITS;
        my = longint'(cur_py) >>> FRAC_BITS;
        fx = longint'(cur_px) & (ONE_Q - 1);
        fy = longint'(cur_py) & (ONE_Q - 1);
        dlx = step_len(rx);
        dly = step_len(ry);
        stx = (rx < 0) ? -1 : 1;
        sty = (ry < 0) ? -1 : 1;
        sx = frac_mul((rx < 0) ? fx : ONE_Q - fx, dlx);
        sy = frac_mul((ry < 0) ? fy : ONE_Q - fy, dly);
        if (mx < MAP_SIZE && my < MAP_SIZE)
        begin
            for (int i = 0; i < 2 * MAP_SIZE + 2; i++)
            begin
                if (sx < sy)
                begin
                    sx += dlx;
                    mx += stx;
                    side = 1'b0;
                end
                else
                begin
                    sy += dly;
                    my += sty;
                    side = 1'b1;
                end
                if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE)
                    break;
                kind = shadow_map[my * MAP_SIZE + mx];
                if (kind != '0)
                begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (!hit)
        begin
            res.left_map = 1'b1;
            return res;
        end
        if (!side)
        begin
            num = mx * ONE_Q - longint'(cur_px) + ((stx < 0) ? ONE_Q : 0);
            wall_d = wall_dist(num, rx);
        end
        else
        begin
            num = my * ONE_Q - longint'(cur_py) + ((sty < 0) ? ONE_Q : 0);
            wall_d = wall_dist(num, ry);
        end
        lh = (wall_d == 0) ? 2 * SCREEN_HEIGHT
                           : (longint'(SCREEN_HEIGHT) << FRAC_BITS) / wall_d;
        if (lh > 2 * SCREEN_HEIGHT)
            lh = 2 * SCREEN_HEIGHT;
        top = SCREEN_HEIGHT / 2 - lh / 2;
        if (top < 0)
            top = 0;
        bot = lh / 2 + SCREEN_HEIGHT / 2;
        if (bot >= SCREEN_HEIGHT)
            bot = SCREEN_HEIGHT - 1;
        case (kind)
            3'd1:    color = 24'hFF0000;
            3'd2:    color = 24'h00FF00;
            3'd3:    color = 24'h0000FF;
            3'd4:    color = 24'hFFFFFF;
            default: color = 24'hFFFF00;
        endcase
        if (side)
            color = color >> 1;
        res.wall_top      = ROW_W'(top);
        res.wall_bottom   = ROW_W'(bot);
        res.wall_color    = color;
        res.hit_side      = side;
        res.wall_distance = DIST_W'(wall_d);
        res.hit_kind      = kind;
        res.hit_x         = MAP_W'(mx);
        res.hit_y         = MAP_W'(my);
        res.left_map      = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, longint got, longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic send_word(bit cmd, logic [COL_W-1:0] col, logic [MAP_W-1:0] x,
                             logic [MAP_W-1:0] y, logic [KIND_W-1:0] kind);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.command   = cmd;
        in_ch.column    = col;
        in_ch.cell_x    = x;
        in_ch.cell_y    = y;
        in_ch.cell_kind = kind;
        in_ch.valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (cmd == CMD_WRITE)
            shadow_map[y * MAP_SIZE + x] = kind;
        else
            column_results_q.push_back(trace_column(col));
        @(negedge clk);
    endtask

    task automatic cast_column(logic [COL_W-1:0] col);
        send_word(CMD_CAST, col, MAP_W'($urandom), MAP_W'($urandom), KIND_W'($urandom));
    endtask

    task automatic write_cell(int x, int y, int kind);
        send_word(CMD_WRITE, COL_W'($urandom), MAP_W'(x), MAP_W'(y), KIND_W'(kind));
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (column_results_q.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then let trailing writes settle before touching a register
    task automatic wait_idle();
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(val);
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_PLAYER_X: cur_px      = POS_W'(val);
            REG_PLAYER_Y: cur_py      = POS_W'(val);
            REG_DIR_X:    cur_dir_x   = VEC_W'(val);
            REG_DIR_Y:    cur_dir_y   = VEC_W'(val);
            REG_PLANE_X:  cur_plane_x = VEC_W'(val);
            default:      cur_plane_y = VEC_W'(val);
        endcase
    endtask

    task automatic set_view(longint px, longint py, longint dx, longint dy,
                            longint cx, longint cy);
        wait_idle();
        write_reg(REG_PLAYER_X, px);
        write_reg(REG_PLAYER_Y, py);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_PLANE_X, cx);
        write_reg(REG_PLANE_Y, cy);
    endtask

    function automatic longint rand_vec();
        return longint'($urandom_range(0, 262144)) - 131072;
    endfunction

    // Empty map: every ray leaves; also columns past the screen edge
    task automatic test_empty_map();
        cast_column(COL_W'(0));
        cast_column(COL_W'(SCREEN_WIDTH - 1));
        cast_column(COL_W'(1023));
    endtask

    // Border of every kind, then casts from the reset view
    task automatic test_border_walls();
        for (int i = 0; i < MAP_SIZE; i++)
        begin
            write_cell(i, 0, 1 + i % 7);
            write_cell(i, MAP_SIZE - 1, 1 + (i + 3) % 7);
            write_cell(0, i, 1 + (i + 5) % 7);
            write_cell(MAP_SIZE - 1, i, 1 + (i + 1) % 7);
        end
        cast_column(COL_W'(0));
        cast_column(COL_W'(320));
        cast_column(COL_W'(SCREEN_WIDTH - 1));
        cast_column(COL_W'(1023));
    endtask

    // Axis-aligned rays, a zero ray, touching walls and extreme vectors
    task automatic test_special_rays();
        set_view(64'd16 << 16, 64'd16 << 16, 65536, 0, 0, 0);
        cast_column(COL_W'(100));
        set_view(64'd16 << 16, 64'd16 << 16, 0, -131072, 0, 0);
        cast_column(COL_W'(5));
        set_view(64'd16 << 16, 64'd16 << 16, 0, 0, 0, 0);
        cast_column(COL_W'(320));
        write_cell(17, 16, 4);
        set_view((64'd17 << 16) - 1, 64'd16 << 16, 131072, 0, 0, 131072);
        cast_column(COL_W'(320));
        cast_column(COL_W'(0));
        cast_column(COL_W'(1023));
        set_view(0, 0, -131072, -131072, -131072, -131072);
        cast_column(COL_W'(0));
        cast_column(COL_W'(639));
        set_view(2097151, 2097151, 131072, 131072, 131072, 131072);
        cast_column(COL_W'(0));
        cast_column(COL_W'(1023));
        write_cell(17, 16, 0);
    endtask

    task automatic test_random_casts(int phase_items, bit with_border, bit with_pause);
        int r;
        set_view($urandom_range(0, 2097151), $urandom_range(0, 2097151),
                 rand_vec(), rand_vec(), rand_vec(), rand_vec());
        if (with_border)
            for (int i = 0; i < MAP_SIZE; i++)
            begin
                write_cell(i, 0, $urandom_range(1, 7));
                write_cell(0, i, $urandom_range(1, 7));
            end
        for (int n = 0; n < phase_items; n++)
        begin
            if (with_pause && n == phase_items / 2)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 40)
                write_cell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7));
            else if (r < 90)
                cast_column(COL_W'($urandom_range(0, SCREEN_WIDTH - 1)));
            else
                cast_column(COL_W'($urandom));
        end
    endtask

    // Result side: random stalls, compare against the oldest prediction
    always @(negedge clk)
    begin
        if (out_taken)
            out_stall = $urandom_range(0, 4);
        else if (out_stall > 0)
            out_stall--;
        out_ch.ready = (out_stall == 0);
    end

    always @(posedge clk)
    begin
        gdr_result_t want;
        out_taken = 1'b0;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            out_taken = 1'b1;
            if (column_results_q.size() == 0)
                report_mismatch("unexpected word", out_ch.out_column, 0);
            else
            begin
                want = column_results_q.pop_front();
                check_field("out_column", out_ch.out_column, want.out_column);
                check_field("wall_top", out_ch.wall_top, want.wall_top);
                check_field("wall_bottom", out_ch.wall_bottom, want.wall_bottom);
                check_field("wall_color", out_ch.wall_color, want.wall_color);
                check_field("hit_side", out_ch.hit_side, want.hit_side);
                check_field("wall_distance", out_ch.wall_distance, want.wall_distance);
                check_field("hit_kind", out_ch.hit_kind, want.hit_kind);
                check_field("hit_x", out_ch.hit_x, want.hit_x);
                check_field("hit_y", out_ch.hit_y, want.hit_y);
                check_field("left_map", out_ch.left_map, want.left_map);
            end
        end
        if ((in_ch.valid && in_ch.ready) || out_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_WRITE;
        in_ch.column    = '0;
        in_ch.cell_x    = '0;
        in_ch.cell_y    = '0;
        in_ch.cell_kind = '0;
        out_ch.ready    = 1'b0;
        out_stall       = 0;
        out_taken       = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        foreach (shadow_map[i])
            shadow_map[i] = '0;
        cur_px      = PLAYER_X_RST;
        cur_py      = PLAYER_Y_RST;
        cur_dir_x   = DIR_X_RST;
        cur_dir_y   = DIR_Y_RST;
        cur_plane_x = PLANE_X_RST;
        cur_plane_y = PLANE_Y_RST;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_map();
        test_border_walls();
        test_special_rays();
        for (int p = 0; p < 6; p++)
            test_random_casts(170, p % 2 == 0, p == 1);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
